@@ rtl/ncol_pkg.sv @@
// ---------------------------------------------------------------------------
// ncol_pkg: shared types and constants of the noise palette colorizer
// Register indexes, scheme codes, palette colors and the front-end bundle
// that feeds the three HSV channel pipes.
// ---------------------------------------------------------------------------
package ncol_pkg;

    // Configuration register indexes.
    localparam logic [3:0] CFG_IDX_SCHEME = 4'd0;
    localparam logic [3:0] CFG_IDX_HUE    = 4'd1;

    // Color scheme codes.
    localparam logic [1:0] SCHEME_FIRE  = 2'd0;
    localparam logic [1:0] SCHEME_SMOKE = 2'd1;
    localparam logic [1:0] SCHEME_METAL = 2'd2;

    // Full scale of the red/blue and green channels.
    localparam logic [5:0] SCALE_5BIT = 6'd31;
    localparam logic [5:0] SCALE_6BIT = 6'd63;

    // One turn of hue is 2^17; the HSV numerator unit is 5 * 2^34.
    localparam logic [17:0] HUE_TURN = 18'h2_0000;
    localparam logic [36:0] HSV_ONE  = 37'h14_0000_0000;

    // Reciprocal of five in Q0.10, exact for operands below 1024.
    localparam logic [7:0] RECIP_FIVE = 8'd205;

    // Bundle handed from the front end to the channel pipes.
    typedef struct packed {
        logic [16:0] v;      // value numerator, v = 65536 + u
        logic [18:0] s;      // saturation numerator, s = 131072 + 3u
        logic [17:0] w_r;    // weight on s for red
        logic [17:0] w_g;    // weight on s for green
        logic [17:0] w_b;    // weight on s for blue
        logic [15:0] pal;    // finished palette pixel
        logic        metal;  // metallic scheme selected
    } t_front;

    // Fixed four-color palettes: fire for scheme 0, smoke for scheme 1.
    function automatic logic [15:0] palette_color(input logic smoke, input logic [1:0] idx);
        logic [15:0] c;
        c = 16'h0000;
        if (smoke) begin
            case (idx)
                2'd0:    c = {5'd8,  6'd8,  5'd8};
                2'd1:    c = {5'd16, 6'd16, 5'd16};
                2'd2:    c = {5'd24, 6'd24, 5'd24};
                default: c = {5'd28, 6'd28, 5'd28};
            endcase
        end else begin
            case (idx)
                2'd0:    c = {5'd31, 6'd0,  5'd0};
                2'd1:    c = {5'd31, 6'd15, 5'd0};
                2'd2:    c = {5'd31, 6'd31, 5'd0};
                default: c = {5'd31, 6'd25, 5'd20};
            endcase
        end
        return c;
    endfunction

endpackage

@@ rtl/noise_palette_colorizer.sv @@
// ---------------------------------------------------------------------------
// noise_palette_colorizer: noise sample to RGB565 pixel
// Maps a signed Q1.15 noise sample to a fire or smoke palette color or to a
// metallic HSV color, one pixel per clock.
// ---------------------------------------------------------------------------
// The block takes one sample in every clock cycle and returns its pixel
// from the end of the pipeline, marked by o_pixel_valid for one
// cycle; pixels leave in the order their samples came in. The six-stage
// pipeline has no feedback, so busy stays low and the result port cannot be
// stalled. The metallic path sets the depth: two multiply stages and the
// merge of the partial products. Write the configuration registers only
// while no pixel is in flight; the configuration channel is always ready.
module noise_palette_colorizer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_noise_sample,
    output logic               o_pixel_valid,
    output logic [15:0]        o_pixel_color,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [3:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    import ncol_pkg::*;

    logic [1:0]  r_color_scheme;
    logic [15:0] r_base_hue;
    logic [5:0]  r_vld;
    logic [15:0] r_pal3;
    logic [15:0] r_pal4;
    logic [15:0] r_pal5;
    logic        r_metal3;
    logic        r_metal4;
    logic        r_metal5;
    logic [15:0] r_pixel;

    t_front      front;
    logic [5:0]  lvl_r;
    logic [5:0]  lvl_g;
    logic [5:0]  lvl_b;
    logic [15:0] n_pixel;
    logic        beat_in;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign beat_in     = start && !busy;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_scheme <= SCHEME_FIRE;
            r_base_hue     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IDX_SCHEME: r_color_scheme <= i_cfg_data[1:0];
                CFG_IDX_HUE:    r_base_hue     <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    // Valid bits that travel with each beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], beat_in};
        end
    end

    // Stages 1 and 2.
    ncol_front u_front (
        .i_clk          (i_clk),
        .i_noise_sample (i_noise_sample),
        .i_color_scheme (r_color_scheme),
        .i_base_hue     (r_base_hue),
        .o_front        (front)
    );

    // Stages 3 to 5, one pipe per channel.
    ncol_chan u_chan_r (
        .i_clk   (i_clk),
        .i_v     (front.v),
        .i_s     (front.s),
        .i_w     (front.w_r),
        .i_scale (SCALE_5BIT),
        .o_level (lvl_r)
    );

    ncol_chan u_chan_g (
        .i_clk   (i_clk),
        .i_v     (front.v),
        .i_s     (front.s),
        .i_w     (front.w_g),
        .i_scale (SCALE_6BIT),
        .o_level (lvl_g)
    );

    ncol_chan u_chan_b (
        .i_clk   (i_clk),
        .i_v     (front.v),
        .i_s     (front.s),
        .i_w     (front.w_b),
        .i_scale (SCALE_5BIT),
        .o_level (lvl_b)
    );

    // Palette pixel and mode bit ride alongside the channel pipes.
    always_ff @(posedge i_clk) begin
        r_pal3   <= front.pal;
        r_pal4   <= r_pal3;
        r_pal5   <= r_pal4;
        r_metal3 <= front.metal;
        r_metal4 <= r_metal3;
        r_metal5 <= r_metal4;
    end

    // Stage 6: select and register the output pixel.
    always_comb begin
        if (r_metal5) begin
            n_pixel = {lvl_r[4:0], lvl_g, lvl_b[4:0]};
        end else begin
            n_pixel = r_pal5;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pixel <= n_pixel;
    end

    assign o_pixel_valid = r_vld[5];
    assign o_pixel_color = r_pixel;

endmodule

@@ rtl/ncol_front.sv @@
// ---------------------------------------------------------------------------
// ncol_front: normalization, hue sector and palette blend
// Two register stages: the first forms u, v, s and the wrapped hue; the
// second splits the hue into sector and fraction, picks the saturation
// weight of each channel and blends the palette pixel.
// ---------------------------------------------------------------------------
module ncol_front (
    input  logic                 i_clk,
    input  logic signed [15:0]   i_noise_sample,
    input  logic [1:0]           i_color_scheme,
    input  logic [15:0]          i_base_hue,
    output ncol_pkg::t_front     o_front
);
    import ncol_pkg::*;

    // Stage 1 registers.
    logic [15:0] r_u1;
    logic [16:0] r_v1;
    logic [18:0] r_s1;
    logic [16:0] r_h1;
    logic [1:0]  r_scheme1;

    logic [15:0] n_u1;
    logic [16:0] n_h1;

    // Stage 2 signals.
    logic [19:0] six;
    logic [2:0]  sector;
    logic [17:0] w_q;
    logic [17:0] w_t;
    logic [1:0]  seg;
    logic [13:0] frac;
    logic [15:0] col_a;
    logic [15:0] col_b;
    logic [5:0]  mix_r;
    logic [5:0]  mix_b;
    logic [15:0] blend;
    t_front      n_front;
    t_front      r_front;

    // Linear blend of one channel across a palette segment, truncated.
    function automatic logic [5:0] mix_chan(input logic [5:0] a, input logic [5:0] b,
                                            input logic [13:0] f);
        logic [14:0] fc;
        logic [20:0] acc;
        fc  = 15'd16384 - {1'b0, f};
        acc = 21'(a) * 21'(fc) + 21'(b) * 21'(f);
        return acc[19:14];
    endfunction

    // Offset binary sample and hue sum, wrapped to one turn.
    always_comb begin
        n_u1 = {~i_noise_sample[15], i_noise_sample[14:0]};
        n_h1 = {i_base_hue, 1'b0} + {1'b0, n_u1};
    end

    // Stage 1: normalized sample, value, saturation and hue.
    always_ff @(posedge i_clk) begin
        r_u1      <= n_u1;
        r_v1      <= 17'h1_0000 + {1'b0, n_u1};
        r_s1      <= 19'h2_0000 + {3'b0, n_u1} + {2'b0, n_u1, 1'b0};
        r_h1      <= n_h1;
        r_scheme1 <= i_color_scheme;
    end

    // Hue sector and fraction, then the weights p, q, t and v put on s.
    always_comb begin
        six    = {1'b0, r_h1, 2'b0} + {2'b0, r_h1, 1'b0};
        sector = six[19:17];
        w_q    = {1'b0, six[16:0]};
        w_t    = HUE_TURN - {1'b0, six[16:0]};

        n_front       = '0;
        n_front.v     = r_v1;
        n_front.s     = r_s1;
        n_front.metal = (r_scheme1 == SCHEME_METAL);

        case (sector)
            3'd0: begin
                n_front.w_r = '0;       n_front.w_g = w_t;      n_front.w_b = HUE_TURN;
            end
            3'd1: begin
                n_front.w_r = w_q;      n_front.w_g = '0;       n_front.w_b = HUE_TURN;
            end
            3'd2: begin
                n_front.w_r = HUE_TURN; n_front.w_g = '0;       n_front.w_b = w_t;
            end
            3'd3: begin
                n_front.w_r = HUE_TURN; n_front.w_g = w_q;      n_front.w_b = '0;
            end
            3'd4: begin
                n_front.w_r = w_t;      n_front.w_g = HUE_TURN; n_front.w_b = '0;
            end
            default: begin
                n_front.w_r = '0;       n_front.w_g = HUE_TURN; n_front.w_b = w_q;
            end
        endcase

        // Palette blend; the last segment returns the last color as is.
        seg   = r_u1[15:14];
        frac  = r_u1[13:0];
        col_a = palette_color(r_scheme1[0], seg);
        col_b = palette_color(r_scheme1[0], seg + 2'd1);
        mix_r = mix_chan({1'b0, col_a[15:11]}, {1'b0, col_b[15:11]}, frac);
        mix_b = mix_chan({1'b0, col_a[4:0]}, {1'b0, col_b[4:0]}, frac);
        blend[15:11] = mix_r[4:0];
        blend[10:5]  = mix_chan(col_a[10:5], col_b[10:5], frac);
        blend[4:0]   = mix_b[4:0];

        if (r_scheme1[1]) begin
            n_front.pal = '0;
        end else if (seg == 2'd3) begin
            n_front.pal = col_a;
        end else begin
            n_front.pal = blend;
        end
    end

    // Stage 2 register.
    always_ff @(posedge i_clk) begin
        r_front <= n_front;
    end

    assign o_front = r_front;

endmodule

@@ rtl/ncol_chan.sv @@
// ---------------------------------------------------------------------------
// ncol_chan: one HSV output channel
// Computes floor(v * (HSV_ONE - w*s) * scale / (5 * 2^51)) over three
// register stages; the final divide by five is a reciprocal multiply.
// ---------------------------------------------------------------------------
module ncol_chan (
    input  logic        i_clk,
    input  logic [16:0] i_v,
    input  logic [18:0] i_s,
    input  logic [17:0] i_w,
    input  logic [5:0]  i_scale,
    output logic [5:0]  o_level
);
    import ncol_pkg::*;

    logic [36:0] r_x3;
    logic [22:0] r_vc3;
    logic [41:0] r_p_lo4;
    logic [40:0] r_p_hi4;
    logic [8:0]  r_y5;

    logic [36:0] ws;
    logic [59:0] sum;
    logic [16:0] quot;

    // Stage 3: channel numerator factor and scaled value.
    always_comb begin
        ws = 37'(i_w) * 37'(i_s);
    end

    always_ff @(posedge i_clk) begin
        r_x3  <= HSV_ONE - ws;
        r_vc3 <= 23'(i_v) * 23'(i_scale);
    end

    // Stage 4: product split into two partial products.
    always_ff @(posedge i_clk) begin
        r_p_lo4 <= 42'(r_vc3) * 42'(r_x3[18:0]);
        r_p_hi4 <= 41'(r_vc3) * 41'(r_x3[36:19]);
    end

    // Stage 5: merge partial products and keep the bits above 2^51.
    always_comb begin
        sum = {r_p_hi4, 19'b0} + 60'(r_p_lo4);
    end

    always_ff @(posedge i_clk) begin
        r_y5 <= sum[59:51];
    end

    // Divide the top bits by five.
    always_comb begin
        quot    = 17'(r_y5) * 17'(RECIP_FIVE);
        o_level = quot[15:10];
    end

endmodule

@@ bench/noise_palette_colorizer_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// noise_palette_colorizer_tb: self-checking bench for the noise colorizer
// Feeds noise samples through the start/busy port under each color scheme
// and several hue offsets, predicts every pixel in the bench and compares
// each pixel beat in order as it leaves the block.
// ---------------------------------------------------------------------------
module noise_palette_colorizer_tb;
    import ncol_pkg::*;

    // Highest register index the port can address; indexes above the hue
    // register hold nothing.
    localparam logic [3:0] CFG_IDX_LAST = 4'd15;

    // Fire and smoke palettes, color 0 in the low 16 bits.
    localparam logic [63:0] FIRE_COLORS  = {{5'd31, 6'd25, 5'd20}, {5'd31, 6'd31, 5'd0},
                                            {5'd31, 6'd15, 5'd0},  {5'd31, 6'd0,  5'd0}};
    localparam logic [63:0] SMOKE_COLORS = {{5'd28, 6'd28, 5'd28}, {5'd24, 6'd24, 5'd24},
                                            {5'd16, 6'd16, 5'd16}, {5'd8,  6'd8,  5'd8}};

    // Metallic mode works in exact rationals over these denominators.
    localparam logic [63:0] TURN    = 64'd131072;
    localparam logic [63:0] SAT_ONE = 64'd655360;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 16;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] i_noise_sample = '0;
    logic               o_pixel_valid;
    logic [15:0]        o_pixel_color;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [3:0]         i_cfg_index = '0;
    logic [15:0]        i_cfg_data = '0;

    logic signed [15:0] pending_samples[$];
    logic [15:0]        pixels_due[$];
    logic [1:0]         cur_scheme;
    logic [15:0]        cur_hue;
    int                 idle_pct = 0;
    int                 mismatches = 0;
    int                 cycle_count = 0;

    noise_palette_colorizer u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_noise_sample (i_noise_sample),
        .o_pixel_valid  (o_pixel_valid),
        .o_pixel_color  (o_pixel_color),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Linear blend of one channel across a palette segment, truncated.
    function automatic int unsigned blend_channel(input int unsigned a, input int unsigned b,
                                                  input int unsigned f);
        return (a * (16384 - f) + b * f) >> 14;
    endfunction

    // Expected pixel for one sample under the given scheme and hue offset.
    function automatic logic [15:0] pixel_for(input logic [1:0] scheme, input logic [15:0] hue,
                                              input logic signed [15:0] sample);
        logic [15:0] u;
        logic [1:0]  seg;
        logic [13:0] frac;
        logic [15:0] ca, cb;
        logic [63:0] uu, v, s, h, six, f, k, den, vn, pn, qn, tn, rn, gn, bn, r, g, b;
        int unsigned cr, cg, cbl;
        // Offset binary form of the sample is n in Q0.16.
        u = {~sample[15], sample[14:0]};
        if (scheme == SCHEME_METAL) begin
            uu  = {48'd0, u};
            v   = 64'd65536 + uu;
            s   = 64'd131072 + 64'd3 * uu;
            h   = (64'd2 * {48'd0, hue} + uu) & (TURN - 64'd1);
            six = 64'd6 * h;
            f   = six & (TURN - 64'd1);
            k   = TURN * SAT_ONE;
            den = k * TURN;
            vn  = v * k;
            pn  = v * (SAT_ONE - s) * TURN;
            qn  = v * (k - f * s);
            tn  = v * (k - (TURN - f) * s);
            case (six >> 17)
                64'd0: begin rn = vn; gn = tn; bn = pn; end
                64'd1: begin rn = qn; gn = vn; bn = pn; end
                64'd2: begin rn = pn; gn = vn; bn = tn; end
                64'd3: begin rn = pn; gn = qn; bn = vn; end
                64'd4: begin rn = tn; gn = pn; bn = vn; end
                default: begin rn = vn; gn = pn; bn = qn; end
            endcase
            r = (rn * 64'd31) / den;
            g = (gn * 64'd63) / den;
            b = (bn * 64'd31) / den;
            return {r[4:0], g[5:0], b[4:0]};
        end
        if (scheme != SCHEME_FIRE && scheme != SCHEME_SMOKE) begin
            return 16'h0000;
        end
        seg  = u[15:14];
        frac = u[13:0];
        if (scheme == SCHEME_FIRE) begin
            ca = FIRE_COLORS[seg * 16 +: 16];
            cb = (seg == 2'd3) ? ca : FIRE_COLORS[(seg + 1) * 16 +: 16];
        end else begin
            ca = SMOKE_COLORS[seg * 16 +: 16];
            cb = (seg == 2'd3) ? ca : SMOKE_COLORS[(seg + 1) * 16 +: 16];
        end
        // The top segment holds the last color with no blend.
        if (seg == 2'd3) begin
            return ca;
        end
        cr  = blend_channel(32'(ca[15:11]), 32'(cb[15:11]), 32'(frac));
        cg  = blend_channel(32'(ca[10:5]), 32'(cb[10:5]), 32'(frac));
        cbl = blend_channel(32'(ca[4:0]), 32'(cb[4:0]), 32'(frac));
        return {cr[4:0], cg[5:0], cbl[4:0]};
    endfunction

    // Random sample, leaning on the ends of the range and segment borders.
    function automatic logic signed [15:0] pick_sample();
        logic signed [15:0] border;
        if ($urandom_range(7) != 0) begin
            return 16'($urandom);
        end
        case ($urandom_range(3))
            0: border = -16'sd32768;
            1: border = -16'sd16384;
            2: border = 16'sd0;
            default: border = 16'sd16384;
        endcase
        return border + $signed(16'($urandom_range(2))) - 16'sd1;
    endfunction

    // One register write beat on the configuration channel.
    task automatic write_cfg(input logic [3:0] idx, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
    endtask

    // Hold off until every queued sample went in and every pixel came out.
    task automatic wait_idle();
        while (pending_samples.size() != 0 || start || pixels_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Bench copy of the configuration registers, updated on each write beat.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_scheme <= SCHEME_FIRE;
            cur_hue    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IDX_SCHEME: cur_scheme <= i_cfg_data[1:0];
                CFG_IDX_HUE:    cur_hue <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sample driver: records the expected pixel of each accepted beat and
    // presents the next queued sample unless this cycle is an idle one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                pixels_due.push_back(pixel_for(cur_scheme, cur_hue, i_noise_sample));
            end
            if (!start || !busy) begin
                if (pending_samples.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    start          <= 1'b1;
                    i_noise_sample <= pending_samples.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Pixel monitor: each pixel beat must match the oldest expected pixel.
    always @(posedge i_clk) begin
        if (i_rst_n && o_pixel_valid === 1'b1) begin
            if (pixels_due.size() == 0) begin
                $display("%0t: pixel with none expected: expected none, actual %h",
                         $time, o_pixel_color);
                mismatches++;
            end else begin
                logic [15:0] want;
                want = pixels_due.pop_front();
                if (o_pixel_color !== want) begin
                    $display("%0t: pixel_color mismatch: expected %h, actual %h",
                             $time, want, o_pixel_color);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("noise_palette_colorizer regression: fail");
            $finish;
        end
    end

    initial begin
        logic [1:0]  scheme;
        logic [15:0] hue;
        int          count;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: every scheme over the range ends and the segment
        // starts, including the unused scheme that gives black.
        idle_pct = 14;
        for (int sc = 0; sc < 4; sc++) begin
            wait_idle();
            write_cfg(CFG_IDX_SCHEME, {14'h3FFF, 2'(sc)});
            pending_samples.push_back(-16'sd32768);
            pending_samples.push_back(-16'sd16384);
            pending_samples.push_back(-16'sd1);
            pending_samples.push_back(16'sd0);
            pending_samples.push_back(16'sd16384);
            pending_samples.push_back(16'sd32767);
        end
        // Hue just below a full turn must wrap around, not go black.
        wait_idle();
        write_cfg(CFG_IDX_SCHEME, {14'd0, SCHEME_METAL});
        write_cfg(CFG_IDX_HUE, 16'hFFFF);
        write_cfg(CFG_IDX_LAST, 16'h0001);
        pending_samples.push_back(16'sd0);
        pending_samples.push_back(-16'sd32768);

        // Random part: twelve settings, idle pattern changing every four.
        for (int p = 0; p < 12; p++) begin
            wait_idle();
            idle_pct = (p < 4) ? 14 : (p < 8) ? 81 : 0;
            scheme = 2'(p % 4);
            hue = (p == 2) ? 16'hFFFF : (p == 6) ? 16'h0000 : 16'($urandom);
            write_cfg(CFG_IDX_SCHEME, {14'($urandom), scheme});
            write_cfg(CFG_IDX_HUE, hue);
            write_cfg(4'($urandom_range(CFG_IDX_LAST, CFG_IDX_HUE + 1)), 16'($urandom));
            count = (scheme > SCHEME_METAL) ? 30 : 140;
            for (int i = 0; i < count; i++) begin
                pending_samples.push_back(pick_sample());
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("noise_palette_colorizer regression: pass");
        end else begin
            $display("noise_palette_colorizer regression: fail");
        end
        $finish;
    end

endmodule
